// ===== src/mqtt_packet_deframer_assert.svh =====
// ----------------------------------------------------------------------------
// mqtt_packet_deframer_assert.svh
// Assertion macros for the packet deframer; compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef MQTT_PACKET_DEFRAMER_ASSERT_SVH
`define MQTT_PACKET_DEFRAMER_ASSERT_SVH

`ifndef ASSERT_OFF

// condition holds at every clock edge out of reset
`define MQTTD_ASSERT_ALWAYS(name, clock, resetn, cond) \
    name: assert property (@(posedge clock) disable iff (!resetn) (cond)) \
        else $error("mqttd assertion failed");

// antecedent implies consequent in the same cycle
`define MQTTD_ASSERT_IMPLIES(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("mqttd assertion failed");

// antecedent implies consequent in the following cycle
`define MQTTD_ASSERT_NEXT(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("mqttd assertion failed");

`else

`define MQTTD_ASSERT_ALWAYS(name, clock, resetn, cond)
`define MQTTD_ASSERT_IMPLIES(name, clock, resetn, ante, cons)
`define MQTTD_ASSERT_NEXT(name, clock, resetn, ante, cons)

`endif

`endif

// ===== src/mqttd_pkg.sv =====
// ----------------------------------------------------------------------------
// mqttd_pkg
// Shared codes, constants and types of the packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package mqttd_pkg;

    localparam int MAX_LENGTH_BYTES = 4;

    localparam logic [27:0] MAX_REM_LEN_RESET = 28'hFFF_FFFF;
    localparam logic [3:0]  PKT_TYPE_PUBLISH  = 4'd3;

    // parse phases
    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_LENGTH  = 3'd1;
    localparam logic [2:0] PH_TOPLEN  = 3'd2;
    localparam logic [2:0] PH_TOPIC   = 3'd3;
    localparam logic [2:0] PH_PKTID   = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;

    // byte roles
    localparam logic [2:0] ROLE_HEADER  = 3'd0;
    localparam logic [2:0] ROLE_LENGTH  = 3'd1;
    localparam logic [2:0] ROLE_TOPLEN  = 3'd2;
    localparam logic [2:0] ROLE_TOPIC   = 3'd3;
    localparam logic [2:0] ROLE_PKTID   = 3'd4;
    localparam logic [2:0] ROLE_PAYLOAD = 3'd5;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_LEN_BYTES = 2'd1;
    localparam logic [1:0] ERR_OVER_MAX  = 2'd2;
    localparam logic [1:0] ERR_TRUNC     = 2'd3;

    // configuration register indexes
    localparam logic CFG_MAX_REM_LEN = 1'b0;
    localparam logic CFG_PUB_DECODE  = 1'b1;

    typedef struct packed {
        logic [27:0] max_rem_len;
        logic        pub_decode_en;
    } mqttd_cfg_t;

    typedef struct packed {
        logic [2:0]  byte_role;
        logic [7:0]  echo_byte;
        logic [3:0]  packet_type;
        logic [3:0]  header_flags;
        logic [27:0] remaining_length;
        logic        length_valid;
        logic [15:0] topic_length;
        logic [15:0] packet_id;
        logic        packet_last;
        logic [1:0]  error_code;
    } mqttd_result_t;

endpackage

`default_nettype wire

// ===== src/mqttd_parser.sv =====
// ----------------------------------------------------------------------------
// mqttd_parser
// Per-packet parse state and the single-pass decode of one stream byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mqttd_parser
    import mqttd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic [7:0]    data_in,
    input  wire mqttd_cfg_t    cfg,
    output mqttd_result_t      result
);

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  hdr_reg, hdr_next;
    logic [27:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [27:0] seen_reg, seen_next;
    logic [15:0] tlen_reg, tlen_next;
    logic [15:0] pid_reg, pid_next;

    logic [2:0]  phase;
    logic [2:0]  nxt;
    logic [2:0]  after_topic;
    logic        body;
    logic [2:0]  role;
    logic        last;
    logic        lvalid;
    logic [1:0]  err;
    logic [27:0] acc_new;
    logic [15:0] tlen_new;

    always_comb
    begin
        phase = (phase_reg > PH_PAYLOAD) ? PH_HEADER : phase_reg;
        after_topic = (hdr_reg[2:1] != 2'b00) ? PH_PKTID : PH_PAYLOAD;

        phase_next = phase;
        hdr_next   = hdr_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        seen_next  = seen_reg;
        tlen_next  = tlen_reg;
        pid_next   = pid_reg;
        nxt        = phase;
        body       = 1'b0;
        role       = ROLE_HEADER;
        last       = 1'b0;
        lvalid     = 1'b0;
        err        = ERR_NONE;
        tlen_new   = tlen_reg | {8'h00, data_in};

        // earlier length bytes only occupy bits below the new group, so OR adds
        case (cnt_reg)
            2'd0:    acc_new = acc_reg | {21'd0, data_in[6:0]};
            2'd1:    acc_new = acc_reg | {14'd0, data_in[6:0], 7'd0};
            2'd2:    acc_new = acc_reg | {7'd0, data_in[6:0], 14'd0};
            default: acc_new = acc_reg | {data_in[6:0], 21'd0};
        endcase

        unique case (phase)
            PH_LENGTH:
            begin
                role     = ROLE_LENGTH;
                acc_next = acc_new;
                if (data_in[7])
                begin
                    if (({1'b0, cnt_reg} + 3'd1) >= 3'(MAX_LENGTH_BYTES))
                    begin
                        err        = ERR_LEN_BYTES;
                        last       = 1'b1;
                        phase_next = PH_HEADER;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 2'd1;
                    end
                end
                else if (acc_new > cfg.max_rem_len)
                begin
                    err        = ERR_OVER_MAX;
                    last       = 1'b1;
                    phase_next = PH_HEADER;
                end
                else
                begin
                    lvalid = 1'b1;
                    if (acc_new == 28'd0)
                    begin
                        last       = 1'b1;
                        phase_next = PH_HEADER;
                    end
                    else if (hdr_reg[7:4] == PKT_TYPE_PUBLISH && cfg.pub_decode_en)
                        phase_next = PH_TOPLEN;
                    else
                        phase_next = PH_PAYLOAD;
                end
            end
            PH_TOPLEN:
            begin
                body = 1'b1;
                role = ROLE_TOPLEN;
                if (seen_reg == 28'd0)
                    tlen_next = {data_in, 8'h00};
                else
                begin
                    tlen_next = tlen_new;
                    nxt       = (tlen_new != 16'd0) ? PH_TOPIC : after_topic;
                end
            end
            PH_TOPIC:
            begin
                body = 1'b1;
                role = ROLE_TOPIC;
                if ({1'b0, seen_reg} >= (29'(tlen_reg) + 29'd1))
                    nxt = after_topic;
            end
            PH_PKTID:
            begin
                body = 1'b1;
                role = ROLE_PKTID;
                if (seen_reg == (28'(tlen_reg) + 28'd2))
                    pid_next = {data_in, 8'h00};
                else
                begin
                    pid_next = pid_reg | {8'h00, data_in};
                    nxt      = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                body = 1'b1;
                role = ROLE_PAYLOAD;
            end
            default:
            begin
                // header byte opens a fresh packet
                role       = ROLE_HEADER;
                hdr_next   = data_in;
                acc_next   = 28'd0;
                cnt_next   = 2'd0;
                seen_next  = 28'd0;
                tlen_next  = 16'd0;
                pid_next   = 16'd0;
                phase_next = PH_LENGTH;
            end
        endcase

        if (body)
        begin
            lvalid    = 1'b1;
            seen_next = seen_reg + 28'd1;
            if (({1'b0, seen_reg} + 29'd1) >= {1'b0, acc_reg})
            begin
                last = 1'b1;
                if (phase != PH_PAYLOAD && nxt != PH_PAYLOAD)
                    err = ERR_TRUNC;
                nxt = PH_HEADER;
            end
            phase_next = nxt;
        end

        result.byte_role        = role;
        result.echo_byte        = data_in;
        result.packet_type      = hdr_next[7:4];
        result.header_flags     = hdr_next[3:0];
        result.remaining_length = acc_next;
        result.length_valid     = lvalid;
        result.topic_length     = tlen_next;
        result.packet_id        = pid_next;
        result.packet_last      = last;
        result.error_code       = err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            hdr_reg   <= 8'h00;
            acc_reg   <= 28'd0;
            cnt_reg   <= 2'd0;
            seen_reg  <= 28'd0;
            tlen_reg  <= 16'd0;
            pid_reg   <= 16'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            hdr_reg   <= hdr_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            seen_reg  <= seen_next;
            tlen_reg  <= tlen_next;
            pid_reg   <= pid_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/mqtt_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// mqtt_packet_deframer
// Byte-serial MQTT packet deframer: tags each stream byte with its role.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with data_byte, one stream byte per
// transaction. Output channel: out_valid / out_stall, one result per input
// byte carrying its role, the echoed byte, header nibbles, remaining length,
// topic length, packet id, packet_last and error_code.
// Throughput is one byte per clock while the receiver does not stall. A byte
// taken in is captured by the input register, then decoded by the single
// decode pass into the result register, from which the result is shown.
// While the receiver stalls, the result holds and the input register keeps
// one further byte; in_stall rises only when both are full.
// Reset empties both registers, returns the parser to await a header byte
// with all packet stores cleared, and loads the register defaults: maximum
// remaining length all ones, PUBLISH decoding on.
// Configuration writes via cfg_write_en / cfg_index / cfg_data, only when idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mqtt_packet_deframer_assert.svh"

module mqtt_packet_deframer
    import mqttd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       byte_role,
    output logic [7:0]       echo_byte,
    output logic [3:0]       packet_type,
    output logic [3:0]       header_flags,
    output logic [27:0]      remaining_length,
    output logic             length_valid,
    output logic [15:0]      topic_length,
    output logic [15:0]      packet_id,
    output logic             packet_last,
    output logic [1:0]       error_code,
    input  wire logic        cfg_write_en,
    input  wire logic        cfg_index,
    input  wire logic [27:0] cfg_data
);

    mqttd_cfg_t    cfg_reg;
    logic          s1_valid_reg;
    logic [7:0]    s1_byte_reg;
    logic          out_valid_reg;
    mqttd_result_t res_reg;
    mqttd_result_t res_next;
    logic          advance;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_rem_len   <= MAX_REM_LEN_RESET;
            cfg_reg.pub_decode_en <= 1'b1;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_MAX_REM_LEN: cfg_reg.max_rem_len   <= cfg_data;
                CFG_PUB_DECODE:  cfg_reg.pub_decode_en <= cfg_data[0];
                default:         cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            s1_byte_reg <= data_byte;
    end

    mqttd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .data_in (s1_byte_reg),
        .cfg     (cfg_reg),
        .result  (res_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid        = out_valid_reg;
    assign byte_role        = res_reg.byte_role;
    assign echo_byte        = res_reg.echo_byte;
    assign packet_type      = res_reg.packet_type;
    assign header_flags     = res_reg.header_flags;
    assign remaining_length = res_reg.remaining_length;
    assign length_valid     = res_reg.length_valid;
    assign topic_length     = res_reg.topic_length;
    assign packet_id        = res_reg.packet_id;
    assign packet_last      = res_reg.packet_last;
    assign error_code       = res_reg.error_code;

    // an error always closes the packet
    `MQTTD_ASSERT_IMPLIES(a_err_closes, clk, rst_n, out_valid_reg && (res_reg.error_code != ERR_NONE), res_reg.packet_last)
    // header bytes never carry a completed length
    `MQTTD_ASSERT_IMPLIES(a_hdr_no_len, clk, rst_n, out_valid_reg && (res_reg.byte_role == ROLE_HEADER), !res_reg.length_valid && !res_reg.packet_last)
    // back-pressure only when both registers are full and the sink stalls
    `MQTTD_ASSERT_IMPLIES(a_stall_cause, clk, rst_n, in_stall, s1_valid_reg && out_valid_reg && out_stall)
    // a packet that closes is followed by a header byte
    `MQTTD_ASSERT_NEXT(a_hdr_after_last, clk, rst_n, advance && res_next.packet_last, u_parser.phase_reg == PH_HEADER)

endmodule

`default_nettype wire

// ===== tb/mqtt_packet_deframer_checker.sv =====
// ----------------------------------------------------------------------------
// mqtt_packet_deframer_checker
// Watches both channels of the deframer, predicts the tag of every byte
// taken in and compares each result transaction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mqtt_packet_deframer_checker
    import mqttd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  byte_role,
    input  logic [7:0]  echo_byte,
    input  logic [3:0]  packet_type,
    input  logic [3:0]  header_flags,
    input  logic [27:0] remaining_length,
    input  logic        length_valid,
    input  logic [15:0] topic_length,
    input  logic [15:0] packet_id,
    input  logic        packet_last,
    input  logic [1:0]  error_code,
    input  logic        cfg_write_en,
    input  logic        cfg_index,
    input  logic [27:0] cfg_data,
    output int          fail_count,
    output int          pending_results
);

    logic [27:0]   max_len_reg;
    logic          decode_reg;
    logic [2:0]    phase;
    logic [7:0]    header_byte;
    logic [27:0]   length_acc;
    logic [1:0]    length_count;
    logic [27:0]   body_count;
    logic [15:0]   topic_len;
    logic [15:0]   pkt_id;
    mqttd_result_t tag_q[$];
    int            mismatches;

    // Advances the parser by one stream byte and returns the tag it should get.
    function automatic mqttd_result_t deframe_byte(input logic [7:0] b);
        mqttd_result_t r;
        logic [2:0]    nxt;
        logic [2:0]    after_topic;
        logic [27:0]   idx;
        r = '0;
        r.echo_byte = b;
        case (phase)
            PH_HEADER:
            begin
                r.byte_role  = ROLE_HEADER;
                header_byte  = b;
                length_acc   = '0;
                length_count = '0;
                body_count   = '0;
                topic_len    = '0;
                pkt_id       = '0;
                phase        = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                r.byte_role = ROLE_LENGTH;
                length_acc  = length_acc + (28'(b[6:0]) << (7 * length_count));
                if (b[7])
                begin
                    if (int'(length_count) + 1 >= MAX_LENGTH_BYTES)
                    begin
                        r.error_code  = ERR_LEN_BYTES;
                        r.packet_last = 1'b1;
                        phase         = PH_HEADER;
                    end
                    else
                        length_count = length_count + 2'd1;
                end
                else if (length_acc > max_len_reg)
                begin
                    r.error_code  = ERR_OVER_MAX;
                    r.packet_last = 1'b1;
                    phase         = PH_HEADER;
                end
                else
                begin
                    r.length_valid = 1'b1;
                    if (length_acc == '0)
                    begin
                        r.packet_last = 1'b1;
                        phase         = PH_HEADER;
                    end
                    else if (header_byte[7:4] == PKT_TYPE_PUBLISH && decode_reg)
                        phase = PH_TOPLEN;
                    else
                        phase = PH_PAYLOAD;
                end
            end
            default:
            begin
                idx            = body_count;
                nxt            = phase;
                r.length_valid = 1'b1;
                r.byte_role    = phase;
                // QoS 3 is malformed but still carries an id
                after_topic = (header_byte[2:1] != 2'b00) ? PH_PKTID : PH_PAYLOAD;
                case (phase)
                    PH_TOPLEN:
                    begin
                        if (idx == '0)
                            topic_len = {b, 8'h00};
                        else
                        begin
                            topic_len = topic_len | {8'h00, b};
                            nxt = (topic_len != '0) ? PH_TOPIC : after_topic;
                        end
                    end
                    PH_TOPIC:
                    begin
                        if (idx >= 1 + topic_len)
                            nxt = after_topic;
                    end
                    PH_PKTID:
                    begin
                        if (idx == 2 + topic_len)
                            pkt_id = {b, 8'h00};
                        else
                        begin
                            pkt_id = pkt_id | {8'h00, b};
                            nxt    = PH_PAYLOAD;
                        end
                    end
                    default: ;
                endcase
                body_count = idx + 28'd1;
                if (idx + 1 >= length_acc)
                begin
                    r.packet_last = 1'b1;
                    // ran out before the variable header was complete
                    if (phase != PH_PAYLOAD && nxt != PH_PAYLOAD)
                        r.error_code = ERR_TRUNC;
                    nxt = PH_HEADER;
                end
                phase = nxt;
            end
        endcase
        r.packet_type      = header_byte[7:4];
        r.header_flags     = header_byte[3:0];
        r.remaining_length = length_acc;
        r.topic_length     = topic_len;
        r.packet_id        = pkt_id;
        return r;
    endfunction

    function automatic int compare_fields(input mqttd_result_t want, input mqttd_result_t got);
        int n;
        n = 0;
        if (got.byte_role !== want.byte_role)
        begin
            $error("byte_role: expected %0d, actual %0d", want.byte_role, got.byte_role);
            n++;
        end
        if (got.echo_byte !== want.echo_byte)
        begin
            $error("echo_byte: expected %02h, actual %02h", want.echo_byte, got.echo_byte);
            n++;
        end
        if (got.packet_type !== want.packet_type)
        begin
            $error("packet_type: expected %0d, actual %0d", want.packet_type, got.packet_type);
            n++;
        end
        if (got.header_flags !== want.header_flags)
        begin
            $error("header_flags: expected %0h, actual %0h",
                   want.header_flags, got.header_flags);
            n++;
        end
        if (got.remaining_length !== want.remaining_length)
        begin
            $error("remaining_length: expected %0d, actual %0d",
                   want.remaining_length, got.remaining_length);
            n++;
        end
        if (got.length_valid !== want.length_valid)
        begin
            $error("length_valid: expected %0b, actual %0b",
                   want.length_valid, got.length_valid);
            n++;
        end
        if (got.topic_length !== want.topic_length)
        begin
            $error("topic_length: expected %0d, actual %0d",
                   want.topic_length, got.topic_length);
            n++;
        end
        if (got.packet_id !== want.packet_id)
        begin
            $error("packet_id: expected %0d, actual %0d", want.packet_id, got.packet_id);
            n++;
        end
        if (got.packet_last !== want.packet_last)
        begin
            $error("packet_last: expected %0b, actual %0b", want.packet_last, got.packet_last);
            n++;
        end
        if (got.error_code !== want.error_code)
        begin
            $error("error_code: expected %0d, actual %0d", want.error_code, got.error_code);
            n++;
        end
        return n;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        mqttd_result_t got;
        if (!rst_n)
        begin
            max_len_reg  = MAX_REM_LEN_RESET;
            decode_reg   = 1'b1;
            phase        = PH_HEADER;
            header_byte  = '0;
            length_acc   = '0;
            length_count = '0;
            body_count   = '0;
            topic_len    = '0;
            pkt_id       = '0;
            tag_q.delete();
            mismatches   = 0;
            fail_count      <= 0;
            pending_results <= 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                if (cfg_index == CFG_MAX_REM_LEN)
                    max_len_reg = cfg_data;
                else
                    decode_reg = cfg_data[0];
            end
            // retire before predicting so a fresh byte cannot mask a stray result
            if (out_valid && !out_stall)
            begin
                got = {byte_role, echo_byte, packet_type, header_flags, remaining_length,
                       length_valid, topic_length, packet_id, packet_last, error_code};
                if (tag_q.size() == 0)
                begin
                    $error("result transaction with nothing outstanding: byte %02h, role %0d",
                           echo_byte, byte_role);
                    mismatches++;
                end
                else
                    mismatches += compare_fields(tag_q.pop_front(), got);
            end
            if (in_valid && !in_stall)
                tag_q.push_back(deframe_byte(data_byte));
            fail_count      <= mismatches;
            pending_results <= tag_q.size();
        end
    end

endmodule

// ===== tb/tb_mqtt_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// tb_mqtt_packet_deframer
// Drives MQTT byte streams into the deframer: a short opening set of corner
// packets, then phases of random well-formed, broken and noisy packets under
// several register settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_mqtt_packet_deframer
    import mqttd_pkg::*;
();

    localparam int RANDOM_ITEMS  = 1600;
    localparam int PHASE_ITEMS   = 180;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int OPENING_COUNT = 26;

    // zero length; QoS 1 publish with topic, id and payload; empty topic;
    // length still continued on its fourth byte; QoS 3 publish cut short before its id
    localparam logic [OPENING_COUNT*8-1:0] OPENING_BYTES = {
        8'hC0, 8'h00,
        8'h32, 8'h07, 8'h00, 8'h01, 8'h61, 8'hAB, 8'hCD, 8'hFF, 8'h00,
        8'h30, 8'h03, 8'h00, 8'h00, 8'h55,
        8'h10, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'h36, 8'h03, 8'h00, 8'h01, 8'h41
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  byte_role;
    logic [7:0]  echo_byte;
    logic [3:0]  packet_type;
    logic [3:0]  header_flags;
    logic [27:0] remaining_length;
    logic        length_valid;
    logic [15:0] topic_length;
    logic [15:0] packet_id;
    logic        packet_last;
    logic [1:0]  error_code;
    logic        cfg_write_en = 1'b0;
    logic        cfg_index = CFG_MAX_REM_LEN;
    logic [27:0] cfg_data = '0;

    int          fail_count;
    int          pending_results;
    int          cycle_count = 0;
    int          bytes_sent = 0;
    int unsigned cur_max = MAX_REM_LEN_RESET;
    bit          quiet = 1'b0;
    logic [7:0]  frame_q[$];

    always #5 clk = ~clk;

    mqtt_packet_deframer DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .data_byte        (data_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .byte_role        (byte_role),
        .echo_byte        (echo_byte),
        .packet_type      (packet_type),
        .header_flags     (header_flags),
        .remaining_length (remaining_length),
        .length_valid     (length_valid),
        .topic_length     (topic_length),
        .packet_id        (packet_id),
        .packet_last      (packet_last),
        .error_code       (error_code),
        .cfg_write_en     (cfg_write_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    mqtt_packet_deframer_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .data_byte        (data_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .byte_role        (byte_role),
        .echo_byte        (echo_byte),
        .packet_type      (packet_type),
        .header_flags     (header_flags),
        .remaining_length (remaining_length),
        .length_valid     (length_valid),
        .topic_length     (topic_length),
        .packet_id        (packet_id),
        .packet_last      (packet_last),
        .error_code       (error_code),
        .cfg_write_en     (cfg_write_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .fail_count       (fail_count),
        .pending_results  (pending_results)
    );

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_q[i])
            send_byte(frame_q[i]);
        frame_q.delete();
    endtask

    // varint remaining length, now and then padded with empty groups
    task automatic push_length(input int unsigned value);
        int nbytes;
        nbytes = 1;
        while (nbytes < MAX_LENGTH_BYTES && (value >> (7 * nbytes)) != 0)
            nbytes++;
        if ($urandom_range(0, 6) == 0)
            nbytes = $urandom_range(nbytes, MAX_LENGTH_BYTES);
        for (int i = 0; i < nbytes; i++)
            frame_q.push_back(8'((value >> (7 * i)) & 127) | ((i < nbytes - 1) ? 8'h80 : 8'h00));
    endtask

    task automatic send_random_packet();
        int unsigned kind;
        int unsigned rem;
        int unsigned tlen_v;
        int unsigned pay;
        int unsigned need;
        logic [3:0]  ptype;
        logic [3:0]  flags;
        logic [15:0] pid_v;
        logic [7:0]  body[$];
        kind  = $urandom_range(0, 99);
        ptype = ($urandom_range(0, 9) < 6) ? PKT_TYPE_PUBLISH : 4'($urandom);
        flags = 4'($urandom);
        pid_v = 16'($urandom);
        if (kind >= 92 && cur_max <= 64)
        begin
            // raw noise; a tight limit keeps any false length short
            repeat ($urandom_range(1, 6))
                frame_q.push_back(8'($urandom));
            send_frame();
            return;
        end
        frame_q.push_back({ptype, flags});
        if (kind < 10)
        begin
            repeat (MAX_LENGTH_BYTES)
                frame_q.push_back(8'h80 | 8'($urandom));
        end
        else if (kind < 20 && cur_max != MAX_REM_LEN_RESET)
            push_length($urandom_range(MAX_REM_LEN_RESET, cur_max + 1));
        else if (kind < 32)
        begin
            // publish whose length ends inside the variable header
            frame_q[0] = {PKT_TYPE_PUBLISH, flags};
            tlen_v = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 6);
            need   = 2 + tlen_v + ((flags[2:1] != 2'b00) ? 2 : 0);
            rem    = $urandom_range(1, (need - 1 < 40) ? need - 1 : 40);
            body.push_back(tlen_v[15:8]);
            body.push_back(tlen_v[7:0]);
            while (body.size() < rem)
                body.push_back(8'($urandom));
            push_length(rem);
        end
        else if (kind < 40)
            push_length(0);
        else
        begin
            if (ptype == PKT_TYPE_PUBLISH)
            begin
                tlen_v = ($urandom_range(0, 49) == 0) ? $urandom_range(256, 300)
                                                      : $urandom_range(0, 12);
                pay    = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 150)
                                                     : $urandom_range(0, 16);
                body.push_back(tlen_v[15:8]);
                body.push_back(tlen_v[7:0]);
                repeat (tlen_v)
                    body.push_back(8'($urandom_range(32, 126)));
                if (flags[2:1] != 2'b00)
                begin
                    body.push_back(pid_v[15:8]);
                    body.push_back(pid_v[7:0]);
                end
                repeat (pay)
                    body.push_back(8'($urandom));
            end
            else
            begin
                repeat ($urandom_range(0, 30))
                    body.push_back(8'($urandom));
            end
            push_length(body.size());
        end
        // an over-limit length ends the packet at the length field
        if (body.size() <= cur_max)
            foreach (body[i])
                frame_q.push_back(body[i]);
        send_frame();
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [27:0] value);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input int unsigned max_len, input logic decode);
        write_reg(CFG_MAX_REM_LEN, 28'(max_len));
        write_reg(CFG_PUB_DECODE, {27'd0, decode});
        cur_max = max_len;
    endtask

    initial
    begin : timeout
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // receiver back-pressure
    initial
    begin : rx_stall
        int n;
        @(posedge rst_n);
        forever
        begin
            n = pick_gap();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int          p;
        int          phase_start;
        int          target;
        int unsigned max_len;
        logic        decode;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = OPENING_COUNT - 1; i >= 0; i--)
            send_byte(OPENING_BYTES[i*8 +: 8]);
        drain();
        // length of 145 against a limit of 16
        set_config(16, 1'b1);
        send_byte(8'hFF);
        send_byte(8'h91);
        send_byte(8'h01);
        drain();

        target = bytes_sent + RANDOM_ITEMS;
        p = 0;
        while (bytes_sent < target)
        begin
            case (p)
                0: begin max_len = MAX_REM_LEN_RESET; decode = 1'b0; end
                1: begin max_len = 0;                 decode = 1'b1; end
                2: begin max_len = 48;                decode = 1'b1; end
                3: begin max_len = MAX_REM_LEN_RESET; decode = 1'b1; end
                default:
                begin
                    case ($urandom_range(0, 6))
                        0: max_len = $urandom_range(1, 64);
                        1: max_len = 127;
                        2: max_len = 128;
                        3: max_len = 16383;
                        4: max_len = 2097152;
                        5: max_len = $urandom_range(0, MAX_REM_LEN_RESET);
                        default: max_len = MAX_REM_LEN_RESET;
                    endcase
                    decode = 1'($urandom_range(0, 1));
                end
            endcase
            set_config(max_len, decode);
            quiet = (p % 3 == 2);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_ITEMS)
                send_random_packet();
            drain();
            p++;
        end

        if (fail_count == 0 && pending_results == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
